// ----- design/rdc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the radix digit converter.
// No dependencies; imported by rdc_ctrl, rdc_dpath and radix_digit_converter.
package rdc_pkg;

  // Width of the base and digit fields
  localparam int unsigned DIGIT_W = 6;

  // Legal range of the target base
  localparam logic [DIGIT_W-1:0] BASE_MIN = 6'd2;
  localparam logic [DIGIT_W-1:0] BASE_MAX = 6'd36;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture value and base, clear remainder
    logic emit_zero;  // present the single word for a zero value
    logic step;       // one restoring division iteration
    logic push;       // push remainder, restart division on the quotient
    logic pop;        // read the top of the digit stack
  } rdc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_zero;     // value on the input port is zero
    logic bit_last;    // this iteration produces the last quotient bit
    logic quo_zero;    // quotient of the finished division is zero
    logic stack_one;   // exactly one digit left on the stack
    logic stack_empty; // digit stack holds nothing
  } rdc_status_t;

endpackage

// ----- design/rdc_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the radix digit converter: divide, push, then pop phases.
// Depends on rdc_pkg for the command and status structs.
module rdc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rdc_pkg::rdc_status_t status,
  output rdc_pkg::rdc_cmd_t    cmd,
  output logic                busy
);
  import rdc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH,
    ST_POP
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (status.in_zero) begin
            cmd.emit_zero = 1'b1;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (status.bit_last) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
        if (status.quo_zero) begin
          state_nxt = ST_POP;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_POP: begin
        cmd.pop = 1'b1;
        if (status.stack_one) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != ST_IDLE);
  end

  // Hold state and the registered busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

`ifndef NO_ASSERTIONS
  // Busy only rises on an accepted start
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(start))
    else $error("busy rose without start");

  // A push always follows a division pass
  a_push_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PUSH |-> $past(state_r) == ST_DIV)
    else $error("push without preceding division");

  // Never pop from an empty stack
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP |-> !status.stack_empty)
    else $error("pop phase with empty stack");
`endif

endmodule

// ----- design/rdc_dpath.sv -----
`timescale 1ns / 1ps
// Datapath for the radix digit converter: bit-serial divider, digit stack
// memory and output registers. Depends on rdc_pkg.
module rdc_dpath #(
  parameter int unsigned MAX_DIGITS = 32,
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rdc_pkg::rdc_cmd_t           cmd,
  input  logic [VALUE_BITS-1:0]       in_value,
  input  logic [rdc_pkg::DIGIT_W-1:0] in_base,
  output rdc_pkg::rdc_status_t        status,
  output logic                        out_strobe,
  output logic [rdc_pkg::DIGIT_W-1:0] out_digit,
  output logic                        out_zero_input,
  output logic                        out_last
);
  import rdc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DIGITS);
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned BW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] div_r, div_nxt;
  logic [DIGIT_W-1:0]    rem_r, rem_nxt;
  logic [DIGIT_W-1:0]    base_r, base_nxt;
  logic [BW-1:0]         bit_cnt_r, bit_cnt_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  strobe_r, zero_r, last_r;
  logic [DIGIT_W-1:0]    rd_data_r;

  logic [DIGIT_W-1:0]    mem [MAX_DIGITS];

  logic [DIGIT_W:0]      rem_sh;
  logic                  rem_ge;
  logic [DIGIT_W:0]      rem_sub;
  logic [DIGIT_W-1:0]    base_clamp;
  logic [CW-1:0]         cnt_dec;
  logic [AW-1:0]         pop_addr;
  logic                  can_push;

  // Clamp the requested base to the legal range
  always_comb begin
    base_clamp = in_base;
    if (in_base < BASE_MIN) begin
      base_clamp = BASE_MIN;
    end else if (in_base > BASE_MAX) begin
      base_clamp = BASE_MAX;
    end
  end

  // One restoring division iteration: shift in a dividend bit, trial subtract
  assign rem_sh  = {rem_r, div_r[VALUE_BITS-1]};
  assign rem_ge  = (rem_sh >= {1'b0, base_r});
  assign rem_sub = rem_sh - {1'b0, base_r};

  assign cnt_dec  = cnt_r - CW'(1);
  assign pop_addr = cnt_dec[AW-1:0];
  assign can_push = (cnt_r < CW'(MAX_DIGITS));

  // Next values for the divider and stack pointer
  always_comb begin
    div_nxt     = div_r;
    rem_nxt     = rem_r;
    base_nxt    = base_r;
    bit_cnt_nxt = bit_cnt_r;
    cnt_nxt     = cnt_r;
    if (cmd.load) begin
      div_nxt     = in_value;
      rem_nxt     = '0;
      base_nxt    = base_clamp;
      bit_cnt_nxt = '0;
    end
    if (cmd.step) begin
      div_nxt     = {div_r[VALUE_BITS-2:0], rem_ge};
      rem_nxt     = rem_ge ? rem_sub[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
      bit_cnt_nxt = bit_cnt_r + BW'(1);
    end
    if (cmd.push) begin
      rem_nxt     = '0;
      bit_cnt_nxt = '0;
      if (can_push) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
    if (cmd.pop) begin
      cnt_nxt = cnt_dec;
    end
  end

  // Hold divider state and stack pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      base_r    <= BASE_MIN;
      bit_cnt_r <= '0;
      cnt_r     <= '0;
    end else begin
      rem_r     <= rem_nxt;
      base_r    <= base_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

  // Digit stack: push the remainder, pop into a registered read word;
  // drop the more significant digits once the stack is full
  always_ff @(posedge clk) begin
    if (cmd.push && can_push) begin
      mem[cnt_r[AW-1:0]] <= rem_r;
    end
    if (cmd.pop) begin
      rd_data_r <= mem[pop_addr];
    end
  end

  // Output strobe and flags, registered in the cycle after the pop or zero detect
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      zero_r   <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      strobe_r <= cmd.pop | cmd.emit_zero;
      zero_r   <= cmd.emit_zero;
      last_r   <= cmd.emit_zero | (cmd.pop && (cnt_r == CW'(1)));
    end
  end

  assign out_strobe     = strobe_r;
  assign out_zero_input = zero_r;
  assign out_last       = last_r;
  assign out_digit      = zero_r ? '0 : rd_data_r;

  // Status back to the controller
  assign status.in_zero     = (in_value == '0);
  assign status.bit_last    = (bit_cnt_r == BW'(VALUE_BITS - 1));
  assign status.quo_zero    = (div_r == '0);
  assign status.stack_one   = (cnt_r == CW'(1));
  assign status.stack_empty = (cnt_r == '0);

`ifndef NO_ASSERTIONS
  // The partial remainder always stays below the base
  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r < base_r)
    else $error("remainder not below base");

  // A digit word comes from a pop in the previous cycle
  a_digit_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !zero_r |-> $past(cmd.pop))
    else $error("digit word without pop");

  // The stack is empty after the last word of a conversion
  a_empty_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> cnt_r == '0)
    else $error("stack not empty after last word");
`endif

endmodule

// ----- design/radix_digit_converter.sv -----
`timescale 1ns / 1ps
// Top level of the radix digit converter: controller plus datapath.
// Depends on rdc_pkg, rdc_ctrl and rdc_dpath.
//
// Usage:
//   Drive in_value and in_base and raise start; the word is taken at a rising
//   edge where start is high and busy is low. Bases below 2 act as 2, bases
//   above 36 act as 36.
//   Each digit appears on out_digit for one cycle with out_strobe high, most
//   significant first; out_last marks the final digit. A zero value gives one
//   word with out_zero_input and out_last set, in the cycle after acceptance,
//   and busy stays low.
//   Each digit takes a division pass over all VALUE_BITS dividend bits in the
//   bit-serial divider (one quotient bit per cycle), plus one push step; the
//   pops then deliver one digit per cycle. The last digit is on the ports in
//   the same cycle as busy falls, and a new start may be taken while that
//   last digit is on the ports.
//   The receiver cannot stall: every strobed word must be taken.
//   Reset (rst_n low, synchronous) returns the block to idle with the digit
//   stack empty; no clearing pass is needed.
module radix_digit_converter #(
  parameter int unsigned MAX_DIGITS = 32,
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [VALUE_BITS-1:0]       in_value,
  input  logic [rdc_pkg::DIGIT_W-1:0] in_base,
  output logic                        out_strobe,
  output logic [rdc_pkg::DIGIT_W-1:0] out_digit,
  output logic                        out_zero_input,
  output logic                        out_last
);
  import rdc_pkg::*;

  rdc_cmd_t    cmd;
  rdc_status_t status;

  // Sequencer
  rdc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Divider, digit stack and output registers
  rdc_dpath #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_value       (in_value),
    .in_base        (in_base),
    .status         (status),
    .out_strobe     (out_strobe),
    .out_digit      (out_digit),
    .out_zero_input (out_zero_input),
    .out_last       (out_last)
  );

endmodule
